>>> rtl/core/rrfp_pkg.sv
// ----------------------------------------------------------------------------
// rrfp_pkg: shared types and constants of the report frame parser
// Frame layout, header and footer patterns, and the control bundle that
// passes from the position tracker to capture and result logic.
// ----------------------------------------------------------------------------
package rrfp_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [4:0] pos_t;
	typedef logic [2:0] cap_idx_t;

	localparam int FRAME_LEN     = 21;
	localparam int HEADER_LEN    = 4;
	localparam int PAYLOAD_FIRST = 8;
	localparam int PAYLOAD_LEN   = 7;
	localparam int FOOTER_FIRST  = 17;

	localparam pos_t POS_LAST    = pos_t'(FRAME_LEN - 1);
	localparam pos_t POS_PAY_LO  = pos_t'(PAYLOAD_FIRST);
	localparam pos_t POS_PAY_HI  = pos_t'(PAYLOAD_FIRST + PAYLOAD_LEN - 1);
	localparam pos_t POS_FOOT_LO = pos_t'(FOOTER_FIRST);
	localparam pos_t POS_HDR_HI  = pos_t'(HEADER_LEN - 1);

	localparam byte_t HEADER_BYTES [HEADER_LEN] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
	localparam byte_t FOOTER_BYTES [HEADER_LEN] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};

	// frame_status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef byte_t payload_t [PAYLOAD_LEN];

	typedef struct packed {
		logic     done;     // good footer on last byte
		logic     error;    // footer byte mismatch
		logic     cap_we;
		cap_idx_t cap_idx;
	} evt_t;

endpackage

>>> rtl/core/rrfp_tracker.sv
// ----------------------------------------------------------------------------
// rrfp_tracker: frame position tracker
// Holds the byte position, checks header and footer bytes and flags the
// payload capture slot, frame completion and footer errors for each processed item.
// ----------------------------------------------------------------------------
module rrfp_tracker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  rrfp_pkg::byte_t rx_byte_s1,
	output rrfp_pkg::evt_t evt
);
	import rrfp_pkg::*;

	pos_t pos_q;
	pos_t pos_eff;
	pos_t pos_next;
	pos_t foot_off;
	pos_t cap_off;
	logic hdr_zone;
	logic foot_zone;
	logic hdr_match;
	logic foot_match;

	always_comb begin
		pos_eff   = (pos_q > POS_LAST) ? '0 : pos_q;
		hdr_zone  = (pos_eff <= POS_HDR_HI);
		foot_zone = (pos_eff >= POS_FOOT_LO);
		foot_off  = pos_eff - POS_FOOT_LO;
		cap_off   = pos_eff - POS_PAY_LO;
		hdr_match  = (rx_byte_s1 == HEADER_BYTES[pos_eff[1:0]]);
		foot_match = (rx_byte_s1 == FOOTER_BYTES[foot_off[1:0]]);

		evt.done    = foot_zone && foot_match && (pos_eff == POS_LAST);
		evt.error   = foot_zone && !foot_match;
		evt.cap_we  = (pos_eff >= POS_PAY_LO) && (pos_eff <= POS_PAY_HI);
		evt.cap_idx = cap_off[2:0];

		if (hdr_zone && !hdr_match) begin
			pos_next = '0;   // mismatching byte is dropped, not retried
		end else if (evt.error || evt.done) begin
			pos_next = '0;
		end else begin
			pos_next = pos_eff + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (fire) begin
			pos_q <= pos_next;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("frame position out of range");

	a_done_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (evt.done || evt.error) |=> pos_q == '0)
		else $error("position not back to hunting after frame end");

endmodule

>>> rtl/core/rrfp_capture.sv
// ----------------------------------------------------------------------------
// rrfp_capture: payload byte capture
// Seven byte registers that take frame bytes 8 to 14 as they pass.
// ----------------------------------------------------------------------------
module rrfp_capture (
	input  logic              clk,
	input  logic              fire,
	input  rrfp_pkg::evt_t    evt,
	input  rrfp_pkg::byte_t   rx_byte_s1,
	output rrfp_pkg::payload_t payload
);
	import rrfp_pkg::*;

	byte_t pay_q [PAYLOAD_LEN];

	always_ff @(posedge clk) begin
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			if (fire && evt.cap_we && (evt.cap_idx == cap_idx_t'(i))) begin
				pay_q[i] <= rx_byte_s1;
			end
		end
	end

	assign payload = pay_q;

endmodule

>>> rtl/core/rrfp_out_reg.sv
// ----------------------------------------------------------------------------
// rrfp_out_reg: result register
// Builds the result fields on frame end and holds them until taken.
// ----------------------------------------------------------------------------
module rrfp_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  rrfp_pkg::evt_t     evt,
	input  rrfp_pkg::payload_t payload,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               frame_status,
	output logic [7:0]         target_state,
	output logic [15:0]        moving_distance,
	output logic [7:0]         moving_energy,
	output logic [15:0]        static_distance,
	output logic [7:0]         static_energy
);
	import rrfp_pkg::*;

	logic load;

	assign space = !out_valid || out_ready;
	assign load  = fire && (evt.done || evt.error);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (space) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && space) begin
			if (evt.error) begin
				frame_status    <= STATUS_ERR;
				target_state    <= '0;
				moving_distance <= '0;
				moving_energy   <= '0;
				static_distance <= '0;
				static_energy   <= '0;
			end else begin
				frame_status    <= STATUS_OK;
				target_state    <= payload[0];
				moving_distance <= {payload[2], payload[1]};
				moving_energy   <= payload[3];
				static_distance <= {payload[5], payload[4]};
				static_energy   <= payload[6];
			end
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status == STATUS_ERR |->
			target_state == '0 && moving_distance == '0 && static_distance == '0)
		else $error("error result carries data");

	a_load_space: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> space)
		else $error("result loaded while register full");

endmodule

>>> rtl/core/radar_report_frame_parser.sv
// A byte that ends a frame passes the input register, then its result is loaded into the result register.
// Throughput: one byte per cycle while the result register has room; input and result registers part the sides.
// A byte leaves the input register only when the result register has room.
// Reset (arst_n low): hunting for the header, no item held in either register.
// Payload registers are not reset; every one is written before a good result.
// ----------------------------------------------------------------------------
// radar_report_frame_parser: 21-byte report frame parser
// Syncs on header F4 F3 F2 F1, captures bytes 8 to 14, checks footer
// F8 F7 F6 F5 and gives one result per finished frame or footer mismatch.
// ----------------------------------------------------------------------------
module radar_report_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_status,
	output logic [7:0]  target_state,
	output logic [15:0] moving_distance,
	output logic [7:0]  moving_energy,
	output logic [15:0] static_distance,
	output logic [7:0]  static_energy
);
	import rrfp_pkg::*;

	logic     valid_s1;
	byte_t    byte_s1;
	logic     space;
	logic     fire;
	evt_t     evt;
	payload_t payload;

	assign fire     = valid_s1 && space;
	assign in_ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	rrfp_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.rx_byte_s1 (byte_s1),
		.evt        (evt)
	);

	rrfp_capture u_capture (
		.clk        (clk),
		.fire       (fire),
		.evt        (evt),
		.rx_byte_s1 (byte_s1),
		.payload    (payload)
	);

	rrfp_out_reg u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.evt             (evt),
		.payload         (payload),
		.space           (space),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_status    (frame_status),
		.target_state    (target_state),
		.moving_distance (moving_distance),
		.moving_energy   (moving_energy),
		.static_distance (static_distance),
		.static_energy   (static_energy)
	);

	a_fire_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> valid_s1 && (!out_valid || out_ready))
		else $error("item processed without room for result");

endmodule
